// ----- src/ofwo_pkg.sv -----
// ----------------------------------------------------------------------------
// Four-wheel omni odometry package
// Shared types and constants for the odometry controller and datapath.
// ----------------------------------------------------------------------------
package ofwo_pkg;

    localparam int ID_W    = 11;
    localparam int DELTA_W = 16;
    localparam int WORD_W  = 32;
    localparam int ACC_W   = 64;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 96;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ID    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_COUNT = 2'd2;

    localparam logic [ID_W-1:0]   RST_FRAME_ID    = 11'd48;
    localparam logic [WORD_W-1:0] RST_DIST_COUNT  = 32'd335544;
    localparam logic [WORD_W-1:0] RST_PHASE_COUNT = 32'd124304;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [15:0] ONE_Q15     = 16'd32768;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_IDLE    = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 4'd1;
    localparam logic [OP_W-1:0] OP_INDEX   = 4'd2;
    localparam logic [OP_W-1:0] OP_RD_SIN  = 4'd3;
    localparam logic [OP_W-1:0] OP_RD_COS  = 4'd4;
    localparam logic [OP_W-1:0] OP_GET_COS = 4'd5;
    localparam logic [OP_W-1:0] OP_MUL_AC  = 4'd6;
    localparam logic [OP_W-1:0] OP_MUL_BS  = 4'd7;
    localparam logic [OP_W-1:0] OP_MUL_AS  = 4'd8;
    localparam logic [OP_W-1:0] OP_MUL_BC  = 4'd9;
    localparam logic [OP_W-1:0] OP_SUM_Y   = 4'd10;
    localparam logic [OP_W-1:0] OP_SCALE_X = 4'd11;
    localparam logic [OP_W-1:0] OP_ADD_X   = 4'd12;
    localparam logic [OP_W-1:0] OP_ADD_Y   = 4'd13;
    localparam logic [OP_W-1:0] OP_HDG_UPD = 4'd14;
    localparam logic [OP_W-1:0] OP_OUT     = 4'd15;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic match;
        logic out_free;
    } status_t;

endpackage

// ----- src/omni_four_wheel_odometry.sv -----
// ----------------------------------------------------------------------------
// Four-wheel omni dead-reckoning odometry
// Rotates omni wheel count deltas by the heading, integrates x and y
// position and a wrapping heading phase, and reports the pose per frame.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  s_       in         s_tvalid / s_tready   frame id, four wheel deltas
//  m_       out        m_tvalid / m_tready   pose x, pose y, heading; accepted flag
//  cfg_     in         cfg_valid / cfg_ready register index, write data
//
//  A frame is sequenced by the controller through the shared 17x17
//  multiplier, the single sine table read port and the scaling multiplier;
//  no new frame is accepted until it is done, and a rejected frame skips
//  straight to the output step. Reset is synchronous; there is no clearing pass.
//  A result waits in the output register; the block stalls only when the
//  next result is ready before the previous one has been taken.
// ----------------------------------------------------------------------------
module omni_four_wheel_odometry #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: frame_id[10:0], delta_wheel0[26:11], delta_wheel1[42:27],
    //          delta_wheel2[58:43], delta_wheel3[74:59], zero fill
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ofwo_pkg::S_TDATA_W-1:0]     s_tdata,
    // m_tdata: pose_x[31:0], pose_y[63:32], heading_phase[95:64]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ofwo_pkg::M_TDATA_W-1:0]     m_tdata,
    // m_tuser: frame_accepted[0]
    output logic                               m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ofwo_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ofwo_pkg::WORD_W-1:0]        cfg_data
);

    ofwo_pkg::cmd_t    cmd;
    ofwo_pkg::status_t status;

    assign cfg_ready = 1'b1;

    ofwo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ofwo_datapath #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- src/ofwo_sine_rom.sv -----
// ----------------------------------------------------------------------------
// Quarter-wave sine table
// Constant sine table of DEPTH+1 entries scaled by 2^15, built at elaboration
// from a fixed-point Taylor series, with a registered read port.
// ----------------------------------------------------------------------------
module ofwo_sine_rom #(
    parameter int DEPTH = 1024
) (
    input  logic                           aclk,
    input  logic [$clog2(DEPTH + 1)-1:0]   addr,
    output logic [15:0]                    data
);

    typedef logic [15:0] rom_arr_t [0:DEPTH];

    function automatic rom_arr_t build_rom();
        rom_arr_t           t;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        r;
        logic signed [63:0] sum;
        for (int k = 0; k <= DEPTH; k++) begin
            x    = (ofwo_pkg::PI_HALF_Q30 * 64'(k)) / 64'(DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = signed'(x);
            for (int n = 1; n <= 10; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0) begin
                sum = '0;
            end
            r = (unsigned'(sum) + 64'd16384) >> 15;
            if (r > 64'(ofwo_pkg::ONE_Q15)) begin
                r = 64'(ofwo_pkg::ONE_Q15);
            end
            t[k] = r[15:0];
        end
        return t;
    endfunction

    localparam rom_arr_t ROM_TABLE = build_rom();

    logic [15:0] data_reg;

    always_ff @(posedge aclk) begin
        data_reg <= ROM_TABLE[addr];
    end

    assign data = data_reg;

endmodule

// ----- src/ofwo_ctrl.sv -----
// ----------------------------------------------------------------------------
// Odometry controller; one operation a cycle unless the output is busy
// Sequences one encoder frame through the datapath.
// ----------------------------------------------------------------------------
module ofwo_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ofwo_pkg::status_t status,
    output ofwo_pkg::cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_INDEX   = 4'd1;
    localparam logic [3:0] ST_RD_SIN  = 4'd2;
    localparam logic [3:0] ST_RD_COS  = 4'd3;
    localparam logic [3:0] ST_GET_COS = 4'd4;
    localparam logic [3:0] ST_MUL_AC  = 4'd5;
    localparam logic [3:0] ST_MUL_BS  = 4'd6;
    localparam logic [3:0] ST_MUL_AS  = 4'd7;
    localparam logic [3:0] ST_MUL_BC  = 4'd8;
    localparam logic [3:0] ST_SUM_Y   = 4'd9;
    localparam logic [3:0] ST_SCALE_X = 4'd10;
    localparam logic [3:0] ST_ADD_X   = 4'd11;
    localparam logic [3:0] ST_ADD_Y   = 4'd12;
    localparam logic [3:0] ST_HDG_UPD = 4'd13;
    localparam logic [3:0] ST_OUT     = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd.op     = ofwo_pkg::OP_IDLE;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = ofwo_pkg::OP_LOAD;
                    state_next = ST_INDEX;
                end
            end
            ST_INDEX: begin
                cmd.op     = ofwo_pkg::OP_INDEX;
                state_next = status.match ? ST_RD_SIN : ST_OUT;
            end
            ST_RD_SIN: begin
                cmd.op     = ofwo_pkg::OP_RD_SIN;
                state_next = ST_RD_COS;
            end
            ST_RD_COS: begin
                cmd.op     = ofwo_pkg::OP_RD_COS;
                state_next = ST_GET_COS;
            end
            ST_GET_COS: begin
                cmd.op     = ofwo_pkg::OP_GET_COS;
                state_next = ST_MUL_AC;
            end
            ST_MUL_AC: begin
                cmd.op     = ofwo_pkg::OP_MUL_AC;
                state_next = ST_MUL_BS;
            end
            ST_MUL_BS: begin
                cmd.op     = ofwo_pkg::OP_MUL_BS;
                state_next = ST_MUL_AS;
            end
            ST_MUL_AS: begin
                cmd.op     = ofwo_pkg::OP_MUL_AS;
                state_next = ST_MUL_BC;
            end
            ST_MUL_BC: begin
                cmd.op     = ofwo_pkg::OP_MUL_BC;
                state_next = ST_SUM_Y;
            end
            ST_SUM_Y: begin
                cmd.op     = ofwo_pkg::OP_SUM_Y;
                state_next = ST_SCALE_X;
            end
            ST_SCALE_X: begin
                cmd.op     = ofwo_pkg::OP_SCALE_X;
                state_next = ST_ADD_X;
            end
            ST_ADD_X: begin
                cmd.op     = ofwo_pkg::OP_ADD_X;
                state_next = ST_ADD_Y;
            end
            ST_ADD_Y: begin
                cmd.op     = ofwo_pkg::OP_ADD_Y;
                state_next = ST_HDG_UPD;
            end
            ST_HDG_UPD: begin
                cmd.op     = ofwo_pkg::OP_HDG_UPD;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.op     = ofwo_pkg::OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

// ----- src/ofwo_datapath.sv -----
// ----------------------------------------------------------------------------
// Odometry datapath
// Configuration registers, pose accumulators, sine lookup, a shared 17x17
// multiplier, the 32x32 scaling multiplier and the result register.
// ----------------------------------------------------------------------------
module ofwo_datapath #(
    parameter int DEPTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ofwo_pkg::cmd_t                       cmd,
    output ofwo_pkg::status_t                    status,
    input  logic [ofwo_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                 cfg_valid,
    input  logic [ofwo_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ofwo_pkg::WORD_W-1:0]          cfg_data,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ofwo_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tuser
);

    localparam int AW  = $clog2(DEPTH + 1);
    localparam int IPW = 30 + AW;

    logic [ofwo_pkg::ID_W-1:0]   frame_id_cfg_reg, frame_id_cfg_next;
    logic [ofwo_pkg::WORD_W-1:0] dist_cfg_reg, dist_cfg_next;
    logic [ofwo_pkg::WORD_W-1:0] phase_cfg_reg, phase_cfg_next;

    logic                        match_reg, match_next;
    logic signed [16:0]          a_reg, a_next;
    logic signed [16:0]          b_reg, b_next;
    logic signed [17:0]          total_reg, total_next;
    logic [AW-1:0]               idx_reg, idx_next;
    logic [1:0]                  quad_reg, quad_next;
    logic signed [16:0]          sin_reg, sin_next;
    logic signed [16:0]          cos_reg, cos_next;
    logic signed [33:0]          p0_reg, p0_next;
    logic signed [33:0]          p1_reg, p1_next;
    logic signed [34:0]          dx_reg, dx_next;
    logic signed [34:0]          dy_reg, dy_next;
    logic [63:0]                 sp_reg, sp_next;
    logic                        sneg_reg, sneg_next;
    logic [31:0]                 dec_reg, dec_next;
    logic [ofwo_pkg::ACC_W-1:0]  x_acc_reg, x_acc_next;
    logic [ofwo_pkg::ACC_W-1:0]  y_acc_reg, y_acc_next;
    logic [31:0]                 heading_reg, heading_next;
    logic [31:0]                 out_x_reg, out_x_next;
    logic [31:0]                 out_y_reg, out_y_next;
    logic [31:0]                 out_h_reg, out_h_next;
    logic                        out_flag_reg, out_flag_next;
    logic                        m_valid_reg, m_valid_next;

    logic [ofwo_pkg::ID_W-1:0]   in_id;
    logic signed [15:0]          d0, d1, d2, d3;
    logic signed [16:0]          a_calc, b_calc;
    logic signed [17:0]          total_calc;
    logic [IPW-1:0]              idx_prod;
    logic [AW-1:0]               idx_raw, idx_calc;
    logic [1:0]                  cos_quad, rd_quad;
    logic [AW-1:0]               rom_addr;
    logic [15:0]                 rom_q;
    logic signed [16:0]          rom_pos, sin_val, cos_val;
    logic                        use_a, use_cos;
    logic signed [16:0]          mul_a, mul_b;
    logic signed [33:0]          prod;
    logic signed [34:0]          scale_src, scale_abs;
    logic                        scale_neg;
    logic [63:0]                 scale_prod;
    logic [63:0]                 inc;
    logic [63:0]                 acc_in, acc_sum;
    logic [31:0]                 total32, dec_prod;

    assign in_id = s_tdata[10:0];
    assign d0    = signed'(s_tdata[26:11]);
    assign d1    = signed'(s_tdata[42:27]);
    assign d2    = signed'(s_tdata[58:43]);
    assign d3    = signed'(s_tdata[74:59]);

    assign a_calc     = 17'(d0) - 17'(d2);
    assign b_calc     = 17'(d1) - 17'(d3);
    assign total_calc = 18'(d0) + 18'(d1) + 18'(d2) + 18'(d3);

    assign idx_prod = IPW'(heading_reg[29:0]) * IPW'(DEPTH);
    assign idx_raw  = idx_prod[IPW-1:30];
    assign idx_calc = (idx_raw > AW'(DEPTH)) ? AW'(DEPTH) : idx_raw;

    assign cos_quad = quad_reg + 2'd1;
    assign rd_quad  = (cmd.op == ofwo_pkg::OP_RD_COS) ? cos_quad : quad_reg;
    assign rom_addr = rd_quad[0] ? (AW'(DEPTH) - idx_reg) : idx_reg;

    ofwo_sine_rom #(
        .DEPTH (DEPTH)
    ) u_rom (
        .aclk (aclk),
        .addr (rom_addr),
        .data (rom_q)
    );

    assign rom_pos = signed'({1'b0, rom_q});
    assign sin_val = quad_reg[1] ? -rom_pos : rom_pos;
    assign cos_val = cos_quad[1] ? -rom_pos : rom_pos;

    assign use_a   = (cmd.op == ofwo_pkg::OP_MUL_AC) || (cmd.op == ofwo_pkg::OP_MUL_AS);
    assign use_cos = (cmd.op == ofwo_pkg::OP_MUL_AC) || (cmd.op == ofwo_pkg::OP_MUL_BC);
    assign mul_a   = use_a ? a_reg : b_reg;
    assign mul_b   = use_cos ? cos_reg : sin_reg;
    assign prod    = 34'(mul_a) * 34'(mul_b);

    assign scale_src  = (cmd.op == ofwo_pkg::OP_SCALE_X) ? dx_reg : dy_reg;
    assign scale_neg  = scale_src[34];
    assign scale_abs  = scale_neg ? -scale_src : scale_src;
    assign scale_prod = 64'(scale_abs[31:0]) * 64'(dist_cfg_reg);

    assign inc     = {15'd0, sp_reg[63:15]};
    assign acc_in  = (cmd.op == ofwo_pkg::OP_ADD_X) ? x_acc_reg : y_acc_reg;
    assign acc_sum = sneg_reg ? (acc_in - inc) : (acc_in + inc);

    assign total32  = 32'(total_reg);
    assign dec_prod = total32 * phase_cfg_reg;

    always_comb begin
        frame_id_cfg_next = frame_id_cfg_reg;
        dist_cfg_next     = dist_cfg_reg;
        phase_cfg_next    = phase_cfg_reg;
        match_next        = match_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        total_next        = total_reg;
        idx_next          = idx_reg;
        quad_next         = quad_reg;
        sin_next          = sin_reg;
        cos_next          = cos_reg;
        p0_next           = p0_reg;
        p1_next           = p1_reg;
        dx_next           = dx_reg;
        dy_next           = dy_reg;
        sp_next           = sp_reg;
        sneg_next         = sneg_reg;
        dec_next          = dec_reg;
        x_acc_next        = x_acc_reg;
        y_acc_next        = y_acc_reg;
        heading_next      = heading_reg;
        out_x_next        = out_x_reg;
        out_y_next        = out_y_reg;
        out_h_next        = out_h_reg;
        out_flag_next     = out_flag_reg;
        m_valid_next      = m_valid_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            case (cfg_index)
                ofwo_pkg::CFG_FRAME_ID:    frame_id_cfg_next = cfg_data[10:0];
                ofwo_pkg::CFG_DIST_COUNT:  dist_cfg_next     = cfg_data;
                ofwo_pkg::CFG_PHASE_COUNT: phase_cfg_next    = cfg_data;
                default: ;
            endcase
        end

        case (cmd.op)
            ofwo_pkg::OP_LOAD: begin
                match_next = (in_id == frame_id_cfg_reg);
                a_next     = a_calc;
                b_next     = b_calc;
                total_next = total_calc;
            end
            ofwo_pkg::OP_INDEX: begin
                idx_next  = idx_calc;
                quad_next = heading_reg[31:30];
            end
            ofwo_pkg::OP_RD_COS: begin
                sin_next = sin_val;
            end
            ofwo_pkg::OP_GET_COS: begin
                cos_next = cos_val;
            end
            ofwo_pkg::OP_MUL_AC: begin
                p0_next = prod;
            end
            ofwo_pkg::OP_MUL_BS: begin
                p1_next = prod;
            end
            ofwo_pkg::OP_MUL_AS: begin
                dx_next = 35'(p0_reg) - 35'(p1_reg);
                p0_next = prod;
            end
            ofwo_pkg::OP_MUL_BC: begin
                p1_next = prod;
            end
            ofwo_pkg::OP_SUM_Y: begin
                dy_next = 35'(p0_reg) + 35'(p1_reg);
            end
            ofwo_pkg::OP_SCALE_X: begin
                sp_next   = scale_prod;
                sneg_next = scale_neg;
            end
            ofwo_pkg::OP_ADD_X: begin
                x_acc_next = acc_sum;
                sp_next    = scale_prod;
                sneg_next  = scale_neg;
            end
            ofwo_pkg::OP_ADD_Y: begin
                y_acc_next = acc_sum;
                dec_next   = dec_prod;
            end
            ofwo_pkg::OP_HDG_UPD: begin
                heading_next = heading_reg - dec_reg;
            end
            ofwo_pkg::OP_OUT: begin
                out_x_next    = x_acc_reg[47:16];
                out_y_next    = y_acc_reg[47:16];
                out_h_next    = heading_reg;
                out_flag_next = match_reg;
                m_valid_next  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_id_cfg_reg <= ofwo_pkg::RST_FRAME_ID;
            dist_cfg_reg     <= ofwo_pkg::RST_DIST_COUNT;
            phase_cfg_reg    <= ofwo_pkg::RST_PHASE_COUNT;
            x_acc_reg        <= '0;
            y_acc_reg        <= '0;
            heading_reg      <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            frame_id_cfg_reg <= frame_id_cfg_next;
            dist_cfg_reg     <= dist_cfg_next;
            phase_cfg_reg    <= phase_cfg_next;
            x_acc_reg        <= x_acc_next;
            y_acc_reg        <= y_acc_next;
            heading_reg      <= heading_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        match_reg    <= match_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        total_reg    <= total_next;
        idx_reg      <= idx_next;
        quad_reg     <= quad_next;
        sin_reg      <= sin_next;
        cos_reg      <= cos_next;
        p0_reg       <= p0_next;
        p1_reg       <= p1_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        sp_reg       <= sp_next;
        sneg_reg     <= sneg_next;
        dec_reg      <= dec_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_h_reg    <= out_h_next;
        out_flag_reg <= out_flag_next;
    end

    assign status.match    = match_reg;
    assign status.out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_h_reg, out_y_reg, out_x_reg};
    assign m_tuser  = out_flag_reg;

endmodule

// ----- src/ofwo_checker.sv -----
// ----------------------------------------------------------------------------
// Odometry port checker
// Concurrent checks on the ports of the odometry block, bound to the top level.
// ----------------------------------------------------------------------------
module ofwo_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [ofwo_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic                              m_tuser
);

    // A waiting result must keep its payload until it is taken.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // After a request is taken the block reports busy while the frame is in progress.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input accepted while a frame was in progress");

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A new result only appears after a frame has been taken.
    a_result_from_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !s_tready || $past(!s_tready))
        else $error("result appeared without a frame in progress");

endmodule

bind omni_four_wheel_odometry ofwo_checker u_ofwo_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
